// ===== sv/assert_macros.svh =====
// Assertion shorthands for the hex text field decoder.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, off during reset
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/hexu8_pkg.sv =====
// Shared types, constants and helper functions for the hex text field decoder.
// No dependencies.
`default_nettype none

package hexu8_pkg;

  // Verdict codes
  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_ABSENT    = 3'd1,
    ERR_ODD       = 3'd2,
    ERR_TOO_LONG  = 3'd3,
    ERR_BAD_HEX   = 3'd4,
    ERR_BAD_UTF8  = 3'd5,
    ERR_FORBIDDEN = 3'd6,
    ERR_BLANK     = 3'd7
  } err_code_t;

  // Register addresses (byte offsets, only bit 2 decoded)
  localparam logic REG_MAX_BYTES     = 1'b0;
  localparam logic REG_TEXT_REQUIRED = 1'b1;

  localparam int          MAX_FIELD_BYTES_DEF = 4096;
  localparam logic [12:0] MAX_BYTES_RST       = 13'd2048;
  localparam logic        TEXT_REQUIRED_RST   = 1'b1;
  localparam logic [13:0] COUNT_MAX           = 14'h3FFF;

  localparam logic [7:0]  CHAR_DASH  = 8'h2D;
  localparam logic [7:0]  LEAD2_MIN  = 8'hC2;
  localparam logic [7:0]  LEAD2_MAX  = 8'hDF;
  localparam logic [7:0]  LEAD4_MIN  = 8'hF0;
  localparam logic [7:0]  LEAD4_MAX  = 8'hF4;

  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;
  localparam logic [20:0] ZW_LO      = 21'h00200B;
  localparam logic [20:0] ZW_HI      = 21'h00200F;
  localparam logic [20:0] BIDI_LO    = 21'h002028;
  localparam logic [20:0] BIDI_HI    = 21'h00202E;
  localparam logic [20:0] WJ_LO      = 21'h002060;
  localparam logic [20:0] WJ_HI      = 21'h00206F;
  localparam logic [20:0] BOM_CP     = 21'h00FEFF;
  localparam logic [20:0] CP_SPACE   = 21'h000020;
  localparam logic [20:0] CP_TAB     = 21'h000009;
  localparam logic [20:0] C1_LO      = 21'h00007F;
  localparam logic [20:0] C1_HI      = 21'h00009F;

  // Running state of one field
  typedef struct packed {
    logic [13:0] char_count;
    logic [3:0]  high_nibble;
    logic [20:0] codepoint_acc;
    logic [1:0]  bytes_pending;
    logic [1:0]  min_class;
    logic        saw_nonspace;
    err_code_t   first_error;
    logic        odd_phase;
    logic        pair_bad;
  } field_state_t;

  localparam field_state_t FIELD_CLEAR = '{
    char_count:    14'd0,
    high_nibble:   4'd0,
    codepoint_acc: 21'd0,
    bytes_pending: 2'd0,
    min_class:     2'd0,
    saw_nonspace:  1'b0,
    first_error:   ERR_OK,
    odd_phase:     1'b0,
    pair_bad:      1'b0
  };

  // Lowercase hex digit: {ok, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Smallest code point allowed for a sequence length class
  function automatic logic [20:0] class_min(input logic [1:0] mc);
    logic [20:0] m;
    case (mc)
      2'd1:    m = 21'h000080;
      2'd2:    m = 21'h000800;
      2'd3:    m = 21'h010000;
      default: m = 21'h000000;
    endcase
    return m;
  endfunction

  // Check a completed code point: overlong, range, surrogates, forbidden chars
  function automatic err_code_t cp_check(input logic [20:0] cp, input logic [1:0] mc);
    err_code_t e;
    e = ERR_OK;
    if (cp < class_min(mc) || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
      e = ERR_BAD_UTF8;
    end else if (cp < CP_SPACE || (cp >= C1_LO && cp <= C1_HI) ||
                 (cp >= ZW_LO && cp <= ZW_HI) || (cp >= BIDI_LO && cp <= BIDI_HI) ||
                 (cp >= WJ_LO && cp <= WJ_HI) || cp == BOM_CP) begin
      e = ERR_FORBIDDEN;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hex_printable_utf8_field_decoder.sv =====
// Top level of the hex text field decoder: input register, per-character
// decode and UTF-8 check, result register, APB-style configuration registers.
// Depends on hexu8_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Takes one character of a lowercase-hex encoded text field per cycle and
// sustains one character per cycle with back-to-back requests while the
// result register is not stalled. Each character is held in the input
// register; its decode, UTF-8 check and verdict are then formed in a single
// pass and loaded into the result register, which holds the result on the
// outputs until it is taken. A result is
// only produced when a hex pair completes to a good byte or when the field ends
// (last or empty_field); other characters just update the running state. A
// stalled result register holds back only characters that produce a result.
// Registers: 0x0 max_bytes (13 bits, limit clamped to MAX_FIELD_BYTES),
// 0x4 text_required (1 bit). Error codes: 0 ok, 1 absent but required,
// 2 odd length, 3 too long, 4 bad hex, 5 bad UTF-8, 6 forbidden character,
// 7 blank.
module hex_printable_utf8_field_decoder #(
  parameter int MAX_FIELD_BYTES = hexu8_pkg::MAX_FIELD_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_in,
  input  wire logic        in_last,
  input  wire logic        in_empty_field,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_byte_valid,
  output logic [7:0]       out_data_byte,
  output logic             out_done_res,
  output logic             out_accepted,
  output logic [2:0]       out_error_code,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import hexu8_pkg::*;

  // Limit clamp, fits the 13-bit register
  localparam logic [12:0] LIMIT_CLAMP =
    (MAX_FIELD_BYTES > 8191) ? 13'h1FFF : 13'(MAX_FIELD_BYTES);

  // Configuration registers
  logic [12:0] max_bytes_r;
  logic        text_required_r;
  logic        cfg_wr;

  // Input register
  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;
  logic        s1_empty_r;

  // Field state
  field_state_t st_r, st_nxt;

  // Result register
  logic        out_valid_r;
  logic        out_byte_valid_r;
  logic [7:0]  out_data_byte_r;
  logic        out_done_r;
  logic        out_accepted_r;
  err_code_t   out_err_r;

  // Per-character decode
  logic [4:0]  hex_dec;
  logic        bvalid;
  logic [7:0]  dbyte;
  logic        absent;
  logic        fin_en;
  logic [20:0] fin_cp;
  logic [1:0]  fin_mc;
  logic [20:0] acc_shift;
  err_code_t   fin_err;
  logic        is_last;
  logic        has_res;
  logic        out_free;
  logic        s1_adv;
  logic [12:0] limit;
  logic        too_long;
  err_code_t   verdict;

  // APB-style access, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_TEXT_REQUIRED) ? {31'd0, text_required_r}
                                                  : {19'd0, max_bytes_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r     <= MAX_BYTES_RST;
      text_required_r <= TEXT_REQUIRED_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_BYTES) begin
        max_bytes_r <= pwdata[12:0];
      end else begin
        text_required_r <= pwdata[0];
      end
    end
  end

  // Decode one character against the running field state
  assign hex_dec   = hex_decode(s1_char_r);
  assign dbyte     = {st_r.high_nibble, hex_dec[3:0]};
  assign acc_shift = {st_r.codepoint_acc[14:0], dbyte[5:0]};

  always_comb begin
    st_nxt  = st_r;
    bvalid  = 1'b0;
    absent  = 1'b0;
    fin_en  = 1'b0;
    fin_cp  = {13'd0, dbyte};
    fin_mc  = 2'd0;
    fin_err = ERR_OK;
    if (!s1_empty_r) begin
      if (st_r.char_count == 14'd0 && s1_char_r == CHAR_DASH && s1_last_r) begin
        absent = 1'b1;
      end
      if (!st_r.odd_phase) begin
        // high nibble of a pair
        st_nxt.pair_bad    = ~hex_dec[4];
        st_nxt.high_nibble = hex_dec[4] ? hex_dec[3:0] : 4'd0;
      end else begin
        // low nibble: pair completes
        if (st_r.pair_bad || !hex_dec[4]) begin
          st_nxt.first_error = ERR_BAD_HEX;
        end else begin
          bvalid = 1'b1;
          if (st_r.first_error == ERR_OK) begin
            if (st_r.bytes_pending == 2'd0) begin
              // lead byte
              if (!dbyte[7]) begin
                st_nxt.min_class = 2'd0;
                fin_en = 1'b1;
              end else if (dbyte >= LEAD2_MIN && dbyte <= LEAD2_MAX) begin
                st_nxt.codepoint_acc = {16'd0, dbyte[4:0]};
                st_nxt.bytes_pending = 2'd1;
                st_nxt.min_class     = 2'd1;
              end else if (dbyte[7:4] == 4'hE) begin
                st_nxt.codepoint_acc = {17'd0, dbyte[3:0]};
                st_nxt.bytes_pending = 2'd2;
                st_nxt.min_class     = 2'd2;
              end else if (dbyte >= LEAD4_MIN && dbyte <= LEAD4_MAX) begin
                st_nxt.codepoint_acc = {18'd0, dbyte[2:0]};
                st_nxt.bytes_pending = 2'd3;
                st_nxt.min_class     = 2'd3;
              end else begin
                st_nxt.first_error   = ERR_BAD_UTF8;
                st_nxt.bytes_pending = 2'd0;
              end
            end else if (dbyte[7:6] != 2'b10) begin
              st_nxt.first_error   = ERR_BAD_UTF8;
              st_nxt.bytes_pending = 2'd0;
            end else begin
              // continuation byte
              st_nxt.codepoint_acc = acc_shift;
              st_nxt.bytes_pending = st_r.bytes_pending - 2'd1;
              if (st_r.bytes_pending == 2'd1) begin
                fin_en = 1'b1;
                fin_cp = acc_shift;
                fin_mc = st_r.min_class;
              end
            end
          end
        end
        st_nxt.pair_bad    = 1'b0;
        st_nxt.high_nibble = 4'd0;
      end
      st_nxt.odd_phase = ~st_r.odd_phase;
      if (st_r.char_count != COUNT_MAX) begin
        st_nxt.char_count = st_r.char_count + 14'd1;
      end
    end
    // completed code point
    if (fin_en) begin
      fin_err = cp_check(fin_cp, fin_mc);
      if (fin_err != ERR_OK) begin
        st_nxt.first_error   = fin_err;
        st_nxt.bytes_pending = 2'd0;
      end else if (fin_cp != CP_SPACE && fin_cp != CP_TAB) begin
        st_nxt.saw_nonspace = 1'b1;
      end
    end
  end

  // Field verdict, in priority order
  assign is_last  = s1_last_r | s1_empty_r;
  assign limit    = (max_bytes_r > LIMIT_CLAMP) ? LIMIT_CLAMP : max_bytes_r;
  assign too_long = {1'b0, st_nxt.char_count} > {1'b0, limit, 1'b0};

  always_comb begin
    verdict = ERR_OK;
    if (absent) begin
      verdict = text_required_r ? ERR_ABSENT : ERR_OK;
    end else if (st_nxt.odd_phase) begin
      verdict = ERR_ODD;
    end else if (too_long) begin
      verdict = ERR_TOO_LONG;
    end else if (st_nxt.first_error != ERR_OK) begin
      verdict = st_nxt.first_error;
    end else if (st_nxt.bytes_pending != 2'd0) begin
      verdict = ERR_BAD_UTF8;
    end else if (text_required_r && !st_nxt.saw_nonspace) begin
      verdict = ERR_BLANK;
    end
  end

  // Flow control: characters without a result never wait on the output
  assign has_res  = is_last | bvalid;
  assign out_free = ~out_valid_r | out_ready;
  assign s1_adv   = s1_valid_r & (~has_res | out_free);
  assign in_ready = ~s1_valid_r | s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r  <= in_char_in;
      s1_last_r  <= in_last;
      s1_empty_r <= in_empty_field;
    end
  end

  // Field state, cleared at the end of each field
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FIELD_CLEAR;
    end else if (s1_adv) begin
      st_r <= is_last ? FIELD_CLEAR : st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_res) begin
      out_byte_valid_r <= bvalid;
      out_data_byte_r  <= bvalid ? dbyte : 8'd0;
      out_done_r       <= is_last;
      out_accepted_r   <= is_last && (verdict == ERR_OK);
      out_err_r        <= is_last ? verdict : ERR_OK;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte_valid = out_byte_valid_r;
  assign out_data_byte  = out_data_byte_r;
  assign out_done_res   = out_done_r;
  assign out_accepted   = out_accepted_r;
  assign out_error_code = out_err_r;

  // Checks
  `ASSERT_IMPLY(a_res_has_cause, out_valid, out_byte_valid || out_done_res,
                "empty result")
  `ASSERT_IMPLY(a_accept_matches_code, out_valid && out_done_res,
                out_accepted == (out_error_code == ERR_OK), "accepted disagrees with code")
  `ASSERT_NEXT(a_field_cleared, s1_adv && is_last,
               st_r.char_count == 14'd0 && !st_r.odd_phase && st_r.first_error == ERR_OK,
               "state not cleared after field end")
  `ASSERT_CLKD(a_pending_class,
               st_r.bytes_pending == 2'd0 || st_r.min_class >= st_r.bytes_pending,
               "pending bytes exceed sequence class")

endmodule

`default_nettype wire
